### rtl/core/lps_pkg.sv
package lps_pkg;

  localparam int unsigned LAYER_W = 11;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COEF_W  = 17;
  localparam int unsigned SUM_W   = 50;
  localparam int unsigned TRUNC_W = 34;
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned PROD_W  = 51;
  localparam int unsigned RES_W   = 52;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COEF_W-1:0] COEF_ONE = 17'h10000;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_GHOST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_GHOST = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [LAYER_W-1:0] layer;
    logic [WORD_W-1:0]  prev_weight;
    logic [WORD_W-1:0]  free_weight;
    logic [COEF_W-1:0]  coef_below;
    logic [COEF_W-1:0]  coef_same;
    logic [COEF_W-1:0]  coef_above;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] new_weight;
    logic              saturated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_B,
    ST_RD_S,
    ST_RD_A,
    ST_ACC_A,
    ST_ACC_END,
    ST_MUL_L,
    ST_MUL_H,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    RD_BELOW,
    RD_SAME,
    RD_ABOVE
  } rd_sel_t;

  typedef enum logic {
    MA_STORE,
    MA_TRUNC
  } mul_a_sel_t;

  typedef enum logic [2:0] {
    MB_CB,
    MB_CS,
    MB_CA,
    MB_GL,
    MB_GH
  } mul_b_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_FRAC
  } acc_op_t;

  typedef struct packed {
    logic       capture;
    logic       store_wr;
    logic       rd_en;
    rd_sel_t    rd_sel;
    mul_a_sel_t mul_a_sel;
    mul_b_sel_t mul_b_sel;
    acc_op_t    acc_op;
    logic       out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic eval_ok;
  } dp_status_t;

endpackage

### rtl/core/lps_ctrl.sv
module lps_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  in_op,
  input  lps_pkg::dp_status_t   status,
  output lps_pkg::ctrl_cmd_t    cmd,
  output logic                  busy,
  output logic                  out_valid
);

  lps_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  assign busy      = (state_r != lps_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd.capture   = 1'b0;
    cmd.store_wr  = 1'b0;
    cmd.rd_en     = 1'b0;
    cmd.rd_sel    = lps_pkg::RD_SAME;
    cmd.mul_a_sel = lps_pkg::MA_STORE;
    cmd.mul_b_sel = lps_pkg::MB_CS;
    cmd.acc_op    = lps_pkg::ACC_HOLD;
    cmd.out_load  = 1'b0;
    case (state_r)
      lps_pkg::ST_IDLE: begin
        cmd.capture  = accept;
        cmd.store_wr = accept && (in_op == lps_pkg::OP_LOAD);
        if (accept && (in_op == lps_pkg::OP_EVAL) && status.eval_ok) begin
          state_nxt = lps_pkg::ST_RD_B;
        end
      end
      lps_pkg::ST_RD_B: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = lps_pkg::RD_BELOW;
        state_nxt  = lps_pkg::ST_RD_S;
      end
      lps_pkg::ST_RD_S: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = lps_pkg::RD_SAME;
        cmd.mul_b_sel = lps_pkg::MB_CB;
        state_nxt     = lps_pkg::ST_RD_A;
      end
      lps_pkg::ST_RD_A: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = lps_pkg::RD_ABOVE;
        cmd.mul_b_sel = lps_pkg::MB_CS;
        cmd.acc_op    = lps_pkg::ACC_LOAD;
        state_nxt     = lps_pkg::ST_ACC_A;
      end
      lps_pkg::ST_ACC_A: begin
        cmd.mul_b_sel = lps_pkg::MB_CA;
        cmd.acc_op    = lps_pkg::ACC_ADD;
        state_nxt     = lps_pkg::ST_ACC_END;
      end
      lps_pkg::ST_ACC_END: begin
        cmd.acc_op = lps_pkg::ACC_ADD;
        state_nxt  = lps_pkg::ST_MUL_L;
      end
      lps_pkg::ST_MUL_L: begin
        cmd.mul_a_sel = lps_pkg::MA_TRUNC;
        cmd.mul_b_sel = lps_pkg::MB_GL;
        state_nxt     = lps_pkg::ST_MUL_H;
      end
      lps_pkg::ST_MUL_H: begin
        cmd.mul_a_sel = lps_pkg::MA_TRUNC;
        cmd.mul_b_sel = lps_pkg::MB_GH;
        cmd.acc_op    = lps_pkg::ACC_FRAC;
        state_nxt     = lps_pkg::ST_FIN;
      end
      lps_pkg::ST_FIN: begin
        cmd.out_load  = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = lps_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/lps_datapath.sv
module lps_datapath #(
  parameter int unsigned MAX_LAYERS = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lps_pkg::in_item_t                   in_item,
  input  logic                                cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lps_pkg::LAYER_W-1:0]         cfg_data,
  input  lps_pkg::ctrl_cmd_t                  cmd,
  output lps_pkg::dp_status_t                 status,
  output lps_pkg::out_item_t                  out_item
);

  localparam int unsigned AW      = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int unsigned LAYER_MAX_FIELD = (1 << lps_pkg::LAYER_W) - 1;
  localparam int unsigned LCAP    = (MAX_LAYERS < LAYER_MAX_FIELD) ? MAX_LAYERS
                                                                    : LAYER_MAX_FIELD;
  localparam logic [lps_pkg::LAYER_W-1:0] LIMIT = lps_pkg::LAYER_W'(LCAP);
  localparam logic [lps_pkg::LAYER_W-1:0] L_ONE = lps_pkg::LAYER_W'(1);

  logic [lps_pkg::LAYER_W-1:0] layer_count_r, lower_src_r, upper_src_r;

  logic [lps_pkg::LAYER_W-1:0] layer_r;
  logic [lps_pkg::WORD_W-1:0]  g1_r;
  logic [lps_pkg::COEF_W-1:0]  cb_r, cs_r, ca_r;

  logic [lps_pkg::WORD_W-1:0]  store_mem [MAX_LAYERS];
  logic [lps_pkg::WORD_W-1:0]  rdata_r;

  logic [lps_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [lps_pkg::PROD_W-1:0]  acc_r;
  lps_pkg::out_item_t          out_r;

  logic [lps_pkg::LAYER_W-1:0] n_eff, lo_src, hi_src, rd_layer, below_layer, above_layer;
  logic [AW-1:0]               mem_addr;
  logic [lps_pkg::MUL_A_W-1:0] mul_a;
  logic [lps_pkg::MUL_B_W-1:0] mul_b;
  logic [lps_pkg::RES_W-1:0]   res;
  logic                        sat;

  function automatic logic [lps_pkg::COEF_W-1:0] clip_coef(
    input logic [lps_pkg::COEF_W-1:0] c
  );
    return (c > lps_pkg::COEF_ONE) ? lps_pkg::COEF_ONE : c;
  endfunction

  function automatic logic [lps_pkg::LAYER_W-1:0] clip_layer(
    input logic [lps_pkg::LAYER_W-1:0] v,
    input logic [lps_pkg::LAYER_W-1:0] n
  );
    logic [lps_pkg::LAYER_W-1:0] r;
    r = v;
    if (v == '0) r = L_ONE;
    else if (v > n) r = n;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_count_r <= lps_pkg::LAYER_W'(1024);
      lower_src_r   <= L_ONE;
      upper_src_r   <= lps_pkg::LAYER_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        lps_pkg::CFG_LAYER_COUNT: layer_count_r <= cfg_data;
        lps_pkg::CFG_LOWER_GHOST: lower_src_r   <= cfg_data;
        lps_pkg::CFG_UPPER_GHOST: upper_src_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n_eff  = clip_layer(layer_count_r, LIMIT);
  assign lo_src = clip_layer(lower_src_r, n_eff);
  assign hi_src = clip_layer(upper_src_r, n_eff);

  assign status.eval_ok = (in_item.layer != '0) && (in_item.layer <= n_eff);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      layer_r <= in_item.layer;
      g1_r    <= in_item.free_weight;
      cb_r    <= clip_coef(in_item.coef_below);
      cs_r    <= clip_coef(in_item.coef_same);
      ca_r    <= clip_coef(in_item.coef_above);
    end
  end

  assign below_layer = (layer_r == L_ONE) ? lo_src : layer_r - L_ONE;
  assign above_layer = (layer_r == n_eff) ? hi_src : layer_r + L_ONE;

  always_comb begin
    case (cmd.rd_sel)
      lps_pkg::RD_BELOW: rd_layer = below_layer;
      lps_pkg::RD_ABOVE: rd_layer = above_layer;
      default:           rd_layer = layer_r;
    endcase
  end

  logic load_ok;
  assign load_ok  = (in_item.layer != '0) && (in_item.layer <= LIMIT);
  assign mem_addr = cmd.store_wr ? AW'(in_item.layer - L_ONE) : AW'(rd_layer - L_ONE);

  always_ff @(posedge clk) begin
    if (cmd.store_wr && load_ok) begin
      store_mem[mem_addr] <= in_item.prev_weight;
    end
    if (cmd.rd_en) begin
      rdata_r <= store_mem[mem_addr];
    end
  end

  always_comb begin
    case (cmd.mul_a_sel)
      lps_pkg::MA_TRUNC: mul_a = acc_r[lps_pkg::SUM_W-1:lps_pkg::FRAC_W];
      default:           mul_a = lps_pkg::MUL_A_W'(rdata_r);
    endcase
    case (cmd.mul_b_sel)
      lps_pkg::MB_CB: mul_b = cb_r;
      lps_pkg::MB_CA: mul_b = ca_r;
      lps_pkg::MB_GL: mul_b = lps_pkg::MUL_B_W'(g1_r[lps_pkg::FRAC_W-1:0]);
      lps_pkg::MB_GH: mul_b = lps_pkg::MUL_B_W'(g1_r[lps_pkg::WORD_W-1:lps_pkg::FRAC_W]);
      default:        mul_b = cs_r;
    endcase
  end

  assign prod_nxt = lps_pkg::PROD_W'(mul_a) * lps_pkg::PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (cmd.acc_op)
      lps_pkg::ACC_LOAD: acc_r <= prod_r;
      lps_pkg::ACC_ADD:  acc_r <= acc_r + prod_r;
      lps_pkg::ACC_FRAC: acc_r <= lps_pkg::PROD_W'(prod_r[lps_pkg::PROD_W-1:lps_pkg::FRAC_W]);
      default:           acc_r <= acc_r;
    endcase
  end

  assign res = lps_pkg::RES_W'(acc_r) + lps_pkg::RES_W'(prod_r);
  assign sat = |res[lps_pkg::RES_W-1:lps_pkg::WORD_W];

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.new_weight <= sat ? '1 : res[lps_pkg::WORD_W-1:0];
      out_r.saturated  <= sat;
    end
  end

  assign out_item = out_r;

endmodule

### rtl/core/lattice_propagator_stencil.sv
// Channel   Ports                                  Transfer
// input     start, busy, in_item                   start && !busy at rising edge
// result    out_valid, out_item                    out_valid high, one cycle, no stall
// config    cfg_we, cfg_index, cfg_data            cfg_we high at rising edge
//
// A load leaves busy low. A valid evaluate holds busy while it makes three reads of
// the single-port weight store, overlapped with five passes through one shared
// 34x17 multiplier; its result strobes in the cycle in which busy falls.
// Reset (rst_n, synchronous) returns the controller to idle and restores the config
// registers; the weight store is not cleared. The receiver cannot stall results.
module lattice_propagator_stencil #(
  parameter int unsigned MAX_LAYERS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lps_pkg::in_item_t             in_item,
  output logic                          out_valid,
  output lps_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lps_pkg::LAYER_W-1:0]   cfg_data
);

  lps_pkg::ctrl_cmd_t  cmd;
  lps_pkg::dp_status_t status;

  lps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_op     (in_item.operation),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  lps_datapath #(
    .MAX_LAYERS (MAX_LAYERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("evaluate finished without result");

  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_wr |-> (!busy && !cmd.rd_en))
    else $error("store write during read sequence");

  a_eval_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.operation == lps_pkg::OP_EVAL) && status.eval_ok)
      |=> busy)
    else $error("valid evaluate transfer not started");
`endif

endmodule

### verif/propagation_checker.sv
`timescale 1ns / 1ps
module propagation_checker #(
  parameter int unsigned MAX_LAYERS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  lps_pkg::in_item_t             in_item,
  input  logic                          out_valid,
  input  lps_pkg::out_item_t            out_item,
  input  logic                          cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lps_pkg::LAYER_W-1:0]   cfg_data,
  output int                            mismatch_count,
  output int                            results_pending
);
  import lps_pkg::*;

  logic [WORD_W-1:0]  layer_weight [1:MAX_LAYERS];
  logic [LAYER_W-1:0] count_reg;
  logic [LAYER_W-1:0] lower_src_reg;
  logic [LAYER_W-1:0] upper_src_reg;
  out_item_t          expected_weights [$];

  function automatic int unsigned clip_to(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [63:0] coef_q16(input logic [COEF_W-1:0] c);
    return (c > COEF_ONE) ? {47'd0, COEF_ONE} : {47'd0, c};
  endfunction

  function automatic bit propagate_layer(input in_item_t it, output out_item_t res);
    int unsigned n;
    int unsigned x;
    int unsigned lo;
    int unsigned hi;
    logic [63:0] gb;
    logic [63:0] gs;
    logic [63:0] ga;
    logic [63:0] sum;
    logic [63:0] t;
    logic [63:0] prod;
    res = '0;
    n = clip_to(count_reg, MAX_LAYERS);
    x = it.layer;
    if (x < 1 || x > n) return 0;
    lo = clip_to(lower_src_reg, n);
    hi = clip_to(upper_src_reg, n);
    gb = {32'd0, layer_weight[(x == 1) ? lo : x - 1]};
    gs = {32'd0, layer_weight[x]};
    ga = {32'd0, layer_weight[(x == n) ? hi : x + 1]};
    sum = coef_q16(it.coef_below) * gb + coef_q16(it.coef_same) * gs
        + coef_q16(it.coef_above) * ga;
    t = sum >> FRAC_W;
    prod = t * {48'd0, it.free_weight[WORD_W-1:FRAC_W]}
         + ((t * {48'd0, it.free_weight[FRAC_W-1:0]}) >> FRAC_W);
    if (prod > 64'hFFFF_FFFF) begin
      res.new_weight = '1;
      res.saturated = 1'b1;
    end else begin
      res.new_weight = prod[WORD_W-1:0];
      res.saturated = 1'b0;
    end
    return 1;
  endfunction

  always @(posedge clk) begin
    out_item_t predicted;
    out_item_t expected;
    if (!rst_n) begin
      count_reg = 11'd1024;
      lower_src_reg = 11'd1;
      upper_src_reg = 11'd1024;
      expected_weights.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LAYER_COUNT: count_reg = cfg_data;
          CFG_LOWER_GHOST: lower_src_reg = cfg_data;
          CFG_UPPER_GHOST: upper_src_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_weights.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %h sat %b",
                   $time, out_item.new_weight, out_item.saturated);
          mismatch_count++;
        end else begin
          expected = expected_weights.pop_front();
          if (out_item.new_weight !== expected.new_weight) begin
            $display("%0t new_weight mismatch: expected %h, actual %h",
                     $time, expected.new_weight, out_item.new_weight);
            mismatch_count++;
          end
          if (out_item.saturated !== expected.saturated) begin
            $display("%0t saturated mismatch: expected %b, actual %b",
                     $time, expected.saturated, out_item.saturated);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        if (in_item.operation == OP_LOAD) begin
          if (in_item.layer >= 1 && in_item.layer <= MAX_LAYERS)
            layer_weight[in_item.layer] = in_item.prev_weight;
        end else if (propagate_layer(in_item, predicted)) begin
          expected_weights.push_back(predicted);
        end
      end
    end
    results_pending = expected_weights.size();
  end

endmodule

### verif/tb_lattice_propagator_stencil.sv
`timescale 1ns / 1ps
module tb_lattice_propagator_stencil;
  import lps_pkg::*;

  localparam int unsigned MAX_LAYERS   = 1024;
  localparam int unsigned PHASE_ITEMS  = 35;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned LOW_FILL     = 64;
  localparam int unsigned HIGH_FILL    = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  in_item_t             in_item   = '0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LAYER_W-1:0]   cfg_data  = '0;
  logic                 busy;
  logic                 out_valid;
  out_item_t            out_item;
  int                   mismatch_count;
  int                   results_pending;

  int unsigned idle_pct      = 36;
  int unsigned active_layers = MAX_LAYERS;
  bit          paused        = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lattice_propagator_stencil #(.MAX_LAYERS(MAX_LAYERS)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  propagation_checker #(.MAX_LAYERS(MAX_LAYERS)) propagation_mon (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item         (in_item),
    .out_valid       (out_valid),
    .out_item        (out_item),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  function automatic logic [WORD_W-1:0] pick_weight();
    case ($urandom_range(4))
      0: return $urandom_range(32'h0002_0000);
      1: return 32'h0000_8000 + $urandom_range(32'h0000_FFFF);
      2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      3: return $urandom_range(32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(9))
      0: return COEF_ONE;
      1: return '0;
      2: return COEF_W'($urandom_range(17'h1FFFF, 17'h10001));
      default: return COEF_W'($urandom_range(17'h10000));
    endcase
  endfunction

  // stencil stays inside the preloaded low and high blocks
  function automatic int unsigned pick_eval_layer();
    if (active_layers <= LOW_FILL) return $urandom_range(active_layers, 1);
    if ($urandom_range(1)) return $urandom_range(LOW_FILL - 1, 1);
    return $urandom_range(MAX_LAYERS, MAX_LAYERS - HIGH_FILL + 2);
  endfunction

  function automatic in_item_t item_of(input logic op, input int unsigned layer,
                                       input logic [WORD_W-1:0] prev,
                                       input logic [WORD_W-1:0] g1,
                                       input logic [COEF_W-1:0] cb,
                                       input logic [COEF_W-1:0] cs,
                                       input logic [COEF_W-1:0] ca);
    in_item_t it;
    it.operation   = op;
    it.layer       = layer[LAYER_W-1:0];
    it.prev_weight = prev;
    it.free_weight = g1;
    it.coef_below  = cb;
    it.coef_same   = cs;
    it.coef_above  = ca;
    return it;
  endfunction

  function automatic in_item_t make_item(input logic op, input int unsigned layer);
    return item_of(op, layer, pick_weight(), pick_weight(), pick_coef(), pick_coef(),
                   pick_coef());
  endfunction

  task automatic transfer_item(input in_item_t item);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [LAYER_W-1:0] lc, input logic [LAYER_W-1:0] lo,
                            input logic [LAYER_W-1:0] hi, input bit poke_unused);
    wait_drained();
    cfg_we <= 1'b1;
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_data  <= LAYER_W'($urandom_range(2047));
      @(posedge clk);
    end
    cfg_index <= CFG_LAYER_COUNT;
    cfg_data  <= lc;
    @(posedge clk);
    cfg_index <= CFG_LOWER_GHOST;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_UPPER_GHOST;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_layers = (lc == 0) ? 1 : ((lc > MAX_LAYERS) ? MAX_LAYERS : lc);
  endtask

  // noise items (bad layers) do not count toward the phase quota
  task automatic random_item(output bit counted);
    int unsigned roll;
    int unsigned layer;
    roll = $urandom_range(99);
    counted = 1'b1;
    if (roll < 65) begin
      case ($urandom_range(3))
        0: layer = 1;
        1: layer = active_layers;
        default: layer = pick_eval_layer();
      endcase
      transfer_item(make_item(OP_EVAL, layer));
    end else if (roll < 88) begin
      transfer_item(make_item(OP_LOAD, $urandom_range(MAX_LAYERS, 1)));
    end else if (roll < 94) begin
      layer = $urandom_range(1) ? 0 : $urandom_range(2047, active_layers + 1);
      transfer_item(make_item(OP_EVAL, layer));
      counted = 1'b0;
    end else begin
      layer = $urandom_range(1) ? 0 : $urandom_range(2047, MAX_LAYERS + 1);
      transfer_item(make_item(OP_LOAD, layer));
      counted = 1'b0;
    end
  endtask

  task automatic run_phase(input logic [LAYER_W-1:0] lc, input logic [LAYER_W-1:0] lo,
                           input logic [LAYER_W-1:0] hi, input int unsigned idle,
                           input bit poke_unused);
    int unsigned counted;
    bit took;
    set_config(lc, lo, hi, poke_unused);
    idle_pct = idle;
    counted = 0;
    while (counted < PHASE_ITEMS) begin
      random_item(took);
      if (took) counted++;
      if (!paused && counted == PHASE_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // low and high blocks written before any evaluate reads them
    for (int unsigned l = 1; l <= LOW_FILL; l++)
      transfer_item(make_item(OP_LOAD, l));
    for (int unsigned l = MAX_LAYERS - HIGH_FILL + 1; l <= MAX_LAYERS; l++)
      transfer_item(make_item(OP_LOAD, l));

    transfer_item(item_of(OP_LOAD, 4, '1, '0, '0, '0, '0));
    transfer_item(item_of(OP_LOAD, 5, '1, '0, '0, '0, '0));
    transfer_item(item_of(OP_LOAD, 6, '1, '0, '0, '0, '0));
    transfer_item(item_of(OP_EVAL, 5, '0, '1, COEF_ONE, COEF_ONE, COEF_ONE));
    transfer_item(item_of(OP_EVAL, 5, '1, '0, COEF_ONE, COEF_ONE, COEF_ONE));
    transfer_item(item_of(OP_EVAL, 5, '1, 32'h0001_0000, '0, '0, '0));
    transfer_item(item_of(OP_LOAD, 8, '0, '1, '1, '1, '1));
    transfer_item(item_of(OP_EVAL, 7, '0, 32'h0001_0000, '1, '1, '1));
    transfer_item(item_of(OP_EVAL, 1, '0, 32'h0001_0000, pick_coef(), pick_coef(),
                          pick_coef()));
    transfer_item(make_item(OP_EVAL, MAX_LAYERS));
    transfer_item(make_item(OP_EVAL, LOW_FILL / 2));
    transfer_item(make_item(OP_EVAL, 0));
    transfer_item(make_item(OP_EVAL, MAX_LAYERS + 1));
    transfer_item(make_item(OP_EVAL, 2047));
    transfer_item(make_item(OP_LOAD, 0));
    transfer_item(make_item(OP_LOAD, MAX_LAYERS + 1));
    transfer_item(make_item(OP_LOAD, 2047));
    transfer_item(item_of(OP_LOAD, MAX_LAYERS, '1, '0, '0, '0, '0));
    transfer_item(item_of(OP_EVAL, MAX_LAYERS - 1, '0, 32'h0002_0000, '0, '0, COEF_ONE));
    transfer_item(item_of(OP_EVAL, 2, '0, 32'h0001_8000, 17'h10001, 17'h10001, '0));
    transfer_item(item_of(OP_EVAL, 3, '0, 32'h0001_0000, COEF_ONE, '0, '0));

    run_phase(11'd1024, 11'd1024, 11'd1,    36, 1'b0);
    run_phase(11'd1,    11'd1,    11'd1,    36, 1'b0);
    run_phase(11'd0,    11'd0,    11'd2047, 36, 1'b1);
    run_phase(11'd2047, 11'd2047, 11'd0,    67, 1'b0);
    run_phase(11'd5,    11'd5,    11'd1,    67, 1'b0);
    run_phase(11'd3,    11'd2,    11'd2,    67, 1'b0);
    run_phase(LAYER_W'($urandom_range(LOW_FILL, 1)), LAYER_W'($urandom_range(2047)),
              LAYER_W'($urandom_range(2047)), 0, 1'b0);
    run_phase(11'd1024, 11'd1,    11'd1024, 0,  1'b0);

    wait_drained();
    if (mismatch_count == 0 && results_pending == 0)
      $display("lattice_propagator_stencil verification clean");
    else
      $display("lattice_propagator_stencil verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("lattice_propagator_stencil verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/core/lps_pkg.sv
rtl/core/lps_ctrl.sv
rtl/core/lps_datapath.sv
rtl/core/lattice_propagator_stencil.sv
verif/propagation_checker.sv
verif/tb_lattice_propagator_stencil.sv
